@@ sv/retransmit_backoff_timer_core_macros.svh @@
// ---------------------------------------------------------------------------
// Retransmit backoff timer assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef RETRANSMIT_BACKOFF_TIMER_CORE_MACROS_SVH
`define RETRANSMIT_BACKOFF_TIMER_CORE_MACROS_SVH

// check a property outside of reset
`define RBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define RBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rbt_pkg.sv @@
// ---------------------------------------------------------------------------
// Retransmit backoff timer package
// Widths, codes, register layout and the interval growth function.
// ---------------------------------------------------------------------------
package rbt_pkg;

  localparam int INTERVAL_BITS = 32;
  localparam int COUNT_BITS    = 9;
  localparam int INIT_BITS     = 16;
  localparam int LIMIT_BITS    = 8;
  localparam int DELTA_BITS    = 4;
  localparam int FACTOR_BITS   = DELTA_BITS + 1;
  localparam int CMP_BITS      = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = INIT_BITS;

  localparam logic [INIT_BITS-1:0]  INIT_INTERVAL_RST = 16'd500;
  localparam logic [LIMIT_BITS-1:0] RETRY_LIMIT_RST   = 8'd3;
  localparam logic [DELTA_BITS-1:0] BACKOFF_DELTA_RST = 4'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INIT_INTERVAL = 2'd0,
    REG_RETRY_LIMIT   = 2'd1,
    REG_BACKOFF_DELTA = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [INIT_BITS-1:0]  init_interval;
    logic [LIMIT_BITS-1:0] retry_limit;
    logic [DELTA_BITS-1:0] backoff_delta;
  } cfg_t;

  typedef struct packed {
    logic                     armed;
    logic [INTERVAL_BITS-1:0] ticks_left;
    logic [INTERVAL_BITS-1:0] cur_interval;
    logic [COUNT_BITS-1:0]    attempts;
  } timer_state_t;

  typedef struct packed {
    logic                  expired;
    logic                  last_attempt;
    logic                  rearmed;
    logic                  running;
    logic [COUNT_BITS-1:0] attempt_count;
  } result_t;

  // Multiply by (1 + delta), saturating at all ones.
  function automatic logic [INTERVAL_BITS-1:0] grow_interval(
    input logic [INTERVAL_BITS-1:0] v,
    input logic [DELTA_BITS-1:0]    delta
  );
    logic [FACTOR_BITS-1:0]               factor;
    logic [INTERVAL_BITS+FACTOR_BITS-1:0] prod;
    factor = FACTOR_BITS'(delta) + FACTOR_BITS'(1);
    prod   = (INTERVAL_BITS+FACTOR_BITS)'(v) * (INTERVAL_BITS+FACTOR_BITS)'(factor);
    if (|prod[INTERVAL_BITS+FACTOR_BITS-1:INTERVAL_BITS]) begin
      return '1;
    end
    return prod[INTERVAL_BITS-1:0];
  endfunction

endpackage

@@ sv/rbt_step.sv @@
// ---------------------------------------------------------------------------
// Retransmit backoff timer step
// Next timer state and result word for one event.
// ---------------------------------------------------------------------------
module rbt_step (
  input  rbt_pkg::timer_state_t state_i,
  input  rbt_pkg::cfg_t         cfg_i,
  input  logic [1:0]            op_i,
  input  logic                  keep_i,
  output rbt_pkg::timer_state_t state_o,
  output rbt_pkg::result_t      res_o
);
  import rbt_pkg::*;

  logic [INTERVAL_BITS-1:0] init_ext;
  logic                     below_limit;
  logic                     at_limit;

  assign init_ext    = INTERVAL_BITS'(cfg_i.init_interval);
  assign below_limit = CMP_BITS'(state_i.attempts) < CMP_BITS'(cfg_i.retry_limit);
  assign at_limit    = !below_limit;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    unique case (op_t'(op_i))
      OP_START: begin
        state_o.cur_interval = init_ext;
        state_o.ticks_left   = init_ext;
        state_o.attempts     = COUNT_BITS'(1);
        state_o.armed        = 1'b1;
      end
      OP_STOP: begin
        state_o.cur_interval = init_ext;
        state_o.attempts     = COUNT_BITS'(1);
        state_o.armed        = 1'b0;
      end
      OP_TICK: begin
        if (state_i.armed) begin
          if (state_i.ticks_left <= INTERVAL_BITS'(1)) begin
            state_o.ticks_left = '0;
            state_o.armed      = 1'b0;
            res_o.expired      = 1'b1;
            res_o.last_attempt = at_limit;
            if (keep_i) begin
              if (state_i.attempts != '1) begin
                state_o.attempts = state_i.attempts + COUNT_BITS'(1);
              end
              if (below_limit) begin
                state_o.cur_interval = grow_interval(state_i.cur_interval,
                                                     cfg_i.backoff_delta);
                state_o.ticks_left   = state_o.cur_interval;
                state_o.armed        = 1'b1;
                res_o.rearmed        = 1'b1;
              end
            end
          end else begin
            state_o.ticks_left = state_i.ticks_left - INTERVAL_BITS'(1);
          end
        end
      end
      OP_NOP: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    res_o.running       = state_o.armed;
    res_o.attempt_count = state_o.attempts;
  end

endmodule

@@ sv/retransmit_backoff_timer_core.sv @@
// ---------------------------------------------------------------------------
// Retransmit backoff timer core
// Countdown timer with multiplicative backoff on retransmit.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per event, in_op selects
//   start, stop, one tick or a no-op; in_keep_retrying is the client reply,
//   used only when a tick expires the countdown.
//   Result channel (out_valid / out_stall): exactly one word per input word,
//   in order: expiry, last attempt, rearm, running flag, attempt count.
//   Config channel (cfg_valid / cfg_ready): index 0 initial interval,
//   1 retry limit, 2 backoff delta; other indexes are dropped. cfg_ready is
//   always high. Write only while no event is in flight; a new initial
//   interval applies from the next start or stop, a new limit or delta
//   from the next expiry. The input register feeds a single update pass
//   into the result register.
//   Throughput: one word per cycle when not stalled; the timer state loops
//   back through one multiply-and-saturate (32 x 5 bits) in the same cycle.
//   Reset (rst_n low, synchronous): registers return to 500 / 3 / 1, the
//   timer is idle with attempt count 1, both pipeline stages are empty.
//   When out_stall is high the result word holds; the input register still
//   fills once, after which in_stall rises until the result is taken.
// ---------------------------------------------------------------------------
module retransmit_backoff_timer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic                                in_keep_retrying,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_expired,
  output logic                                out_last_attempt,
  output logic                                out_rearmed,
  output logic                                out_running,
  output logic [rbt_pkg::COUNT_BITS-1:0]      out_attempt_count,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rbt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import rbt_pkg::*;

  cfg_t         cfg_r;
  timer_state_t state_r;
  timer_state_t state_nxt;
  result_t      res_nxt;
  result_t      res_r;

  logic         in_vld_r;
  logic [1:0]   op_r;
  logic         keep_r;
  logic         out_vld_r;

  logic         out_free;
  logic         stage_adv;
  logic         in_take;

  // Output slot is free when empty or being drained this cycle.
  assign out_free  = !out_vld_r || !out_stall;
  assign stage_adv = in_vld_r && out_free;
  // Input register takes a word when empty or moving forward.
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_interval <= INIT_INTERVAL_RST;
      cfg_r.retry_limit   <= RETRY_LIMIT_RST;
      cfg_r.backoff_delta <= BACKOFF_DELTA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INIT_INTERVAL: cfg_r.init_interval <= cfg_data[INIT_BITS-1:0];
        REG_RETRY_LIMIT:   cfg_r.retry_limit   <= cfg_data[LIMIT_BITS-1:0];
        REG_BACKOFF_DELTA: cfg_r.backoff_delta <= cfg_data[DELTA_BITS-1:0];
        REG_UNUSED: begin
          // drop writes past the register list
        end
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (stage_adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_op;
      keep_r <= in_keep_retrying;
    end
  end

  // Single update pass: state and result from the held event
  rbt_step u_step (
    .state_i (state_r),
    .cfg_i   (cfg_r),
    .op_i    (op_r),
    .keep_i  (keep_r),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  // Timer state commits only when the event moves into the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.armed        <= 1'b0;
      state_r.ticks_left   <= '0;
      state_r.cur_interval <= INTERVAL_BITS'(INIT_INTERVAL_RST);
      state_r.attempts     <= COUNT_BITS'(1);
    end else if (stage_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_expired       = res_r.expired;
  assign out_last_attempt  = res_r.last_attempt;
  assign out_rearmed       = res_r.rearmed;
  assign out_running       = res_r.running;
  assign out_attempt_count = res_r.attempt_count;

endmodule

@@ sv/rbt_checker.sv @@
// ---------------------------------------------------------------------------
// Retransmit backoff timer checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
`include "retransmit_backoff_timer_core_macros.svh"

module rbt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_expired,
  input logic                           out_last_attempt,
  input logic                           out_rearmed,
  input logic                           out_running,
  input logic [rbt_pkg::COUNT_BITS-1:0] out_attempt_count
);
  import rbt_pkg::*;

  // no result word right after reset
  `RBT_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result word stays
  `RBT_ASSERT(a_hold_on_stall, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a rearm keeps the countdown running past the first attempt
  `RBT_ASSERT(a_rearm_running, out_valid && out_rearmed |-> out_expired && out_running && out_attempt_count != COUNT_BITS'(1), "rearm without expiry or run")

  // an expiry that is not rearmed leaves the timer idle
  `RBT_ASSERT(a_expire_idle, out_valid && out_expired && !out_rearmed |-> !out_running, "timer running after final expiry")

  // last attempt is only reported on an expiry
  `RBT_ASSERT(a_last_on_expiry, out_valid && out_last_attempt |-> out_expired, "last attempt flag without expiry")

endmodule

bind retransmit_backoff_timer_core rbt_checker u_rbt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_expired       (out_expired),
  .out_last_attempt  (out_last_attempt),
  .out_rearmed       (out_rearmed),
  .out_running       (out_running),
  .out_attempt_count (out_attempt_count)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Retransmit backoff timer testbench
// Drives start, stop, tick and no-op words into the timer core with random
// gaps and output stalls, and checks every result word against a cycle-free
// model of the countdown, the attempt counter and the interval growth.
// ---------------------------------------------------------------------------
module tb_top;
  import rbt_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 4;    // two pipeline stages plus margin
  localparam int HOLD_CYCLES    = 60;   // long result back-pressure stretch
  localparam int WATCHDOG_LIMIT = 2000;

  // -------------------------------------------------------------------------
  // Timer model and result store
  // -------------------------------------------------------------------------
  class timer_scoreboard;
    logic [INIT_BITS-1:0]     init_interval;
    logic [LIMIT_BITS-1:0]    retry_limit;
    logic [DELTA_BITS-1:0]    backoff_delta;
    bit                       armed;
    logic [INTERVAL_BITS-1:0] ticks_left;
    logic [INTERVAL_BITS-1:0] cur_interval;
    logic [COUNT_BITS-1:0]    attempts;
    result_t                  expected_words[$];
    int unsigned              errors;

    function new();
      init_interval = INIT_INTERVAL_RST;
      retry_limit   = RETRY_LIMIT_RST;
      backoff_delta = BACKOFF_DELTA_RST;
      armed         = 1'b0;
      ticks_left    = '0;
      cur_interval  = INTERVAL_BITS'(INIT_INTERVAL_RST);
      attempts      = COUNT_BITS'(1);
      errors        = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_INIT_INTERVAL: init_interval = data[INIT_BITS-1:0];
        REG_RETRY_LIMIT:   retry_limit   = data[LIMIT_BITS-1:0];
        REG_BACKOFF_DELTA: backoff_delta = data[DELTA_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Multiply by (1 + delta) and clamp to the interval width.
    function logic [INTERVAL_BITS-1:0] backoff(logic [INTERVAL_BITS-1:0] v);
      longint unsigned prod;
      prod = longint'(v) * (longint'(backoff_delta) + 1);
      if (prod > longint'({INTERVAL_BITS{1'b1}})) return '1;
      return prod[INTERVAL_BITS-1:0];
    endfunction

    function void note_input(op_t op, bit keep);
      result_t                r;
      logic [COUNT_BITS-1:0]  old_attempts;
      r = '0;
      case (op)
        OP_START: begin
          cur_interval = INTERVAL_BITS'(init_interval);
          attempts     = COUNT_BITS'(1);
          ticks_left   = cur_interval;
          armed        = 1'b1;
        end
        OP_STOP: begin
          armed        = 1'b0;
          cur_interval = INTERVAL_BITS'(init_interval);
          attempts     = COUNT_BITS'(1);
        end
        OP_TICK: begin
          if (armed) begin
            if (ticks_left <= 1) begin
              old_attempts   = attempts;
              ticks_left     = '0;
              r.expired      = 1'b1;
              r.last_attempt = (attempts >= COUNT_BITS'(retry_limit));
              armed          = 1'b0;
              if (keep) begin
                if (attempts != '1) attempts = attempts + 1'b1;
                if (old_attempts < COUNT_BITS'(retry_limit)) begin
                  cur_interval = backoff(cur_interval);
                  ticks_left   = cur_interval;
                  armed        = 1'b1;
                  r.rearmed    = 1'b1;
                end
              end
            end else begin
              ticks_left = ticks_left - 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.running       = armed;
      r.attempt_count = attempts;
      expected_words.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", act);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      cmp_field("expired", exp_w.expired, act.expired);
      cmp_field("last_attempt", exp_w.last_attempt, act.last_attempt);
      cmp_field("rearmed", exp_w.rearmed, act.rearmed);
      cmp_field("running", exp_w.running, act.running);
      cmp_field("attempt_count", exp_w.attempt_count, act.attempt_count);
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  typedef struct {
    int unsigned init_iv;
    int unsigned limit;
    int unsigned delta;
    int unsigned n_words;
    bit          chain;     // start once, then tick with retry every word
    bit          eager;     // no gaps and no stalls in this phase
    bit          hold;      // one long result stall in this phase
  } phase_t;

  // -------------------------------------------------------------------------
  // Signals
  // -------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = OP_NOP;
  logic                     in_keep_retrying = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_expired;
  logic                     out_last_attempt;
  logic                     out_rearmed;
  logic                     out_running;
  logic [COUNT_BITS-1:0]    out_attempt_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_INIT_INTERVAL;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  timer_scoreboard sb = new();
  int unsigned     tx_gap_max = 3;
  int unsigned     rx_stall_max = 3;
  bit              hold_req = 1'b0;
  int unsigned     idle_cycles = 0;

  always #(CLK_HALF) clk = ~clk;

  retransmit_backoff_timer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_keep_retrying  (in_keep_retrying),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_expired       (out_expired),
    .out_last_attempt  (out_last_attempt),
    .out_rearmed       (out_rearmed),
    .out_running       (out_running),
    .out_attempt_count (out_attempt_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Offer one event word after a random gap; hold it until the core takes it.
  task automatic send(op_t op, bit keep);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_keep_retrying <= keep;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, keep);
  endtask

  // Leave cfg_valid high on return; the caller lowers it after the last write.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Wait for every expected word, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Upper data bits of the narrow registers are don't-care; fill them randomly.
  task automatic program_regs(int unsigned init_iv, int unsigned limit, int unsigned delta);
    write_reg(REG_INIT_INTERVAL, CFG_DATA_BITS'(init_iv));
    write_reg(REG_RETRY_LIMIT, {CFG_DATA_BITS'($urandom) & ~16'hFF} | CFG_DATA_BITS'(limit));
    write_reg(REG_BACKOFF_DELTA, {CFG_DATA_BITS'($urandom) & ~16'hF} | CFG_DATA_BITS'(delta));
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Pick the next event: mostly start-then-tick runs, some stops and no-ops.
  task automatic send_random(bit chain);
    int unsigned pick;
    bit          keep;
    keep = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (chain) begin
      send(OP_TICK, 1'b1);
    end else if (!sb.armed && pick < 50) begin
      send(OP_START, keep);
    end else if (pick < 5) begin
      send(OP_START, keep);
    end else if (pick < 9) begin
      send(OP_STOP, keep);
    end else if (pick < 12) begin
      send(OP_NOP, keep);
    end else begin
      send(OP_TICK, keep);
    end
  endtask

  // -------------------------------------------------------------------------
  // Result sink: random stalls per word, one long hold on request
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_n  = HOLD_CYCLES;
      end else begin
        stall_n = $urandom_range(0, rx_stall_max);
      end
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check each accepted result word.
  always @(posedge clk) begin
    result_t act;
    if (rst_n && out_valid && !out_stall) begin
      act.expired       = out_expired;
      act.last_attempt  = out_last_attempt;
      act.rearmed       = out_rearmed;
      act.running       = out_running;
      act.attempt_count = out_attempt_count;
      sb.check_result(act);
    end
  end

  // Count cycles without any handshake; give up when the core stops moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    phase_t      phases[$];
    phase_t      ph;
    int unsigned k;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero interval, last attempt, idle tick, restart, no-op.
    program_regs(0, 2, 15);
    send(OP_TICK, 1'b1);     // tick while idle
    send(OP_NOP, 1'b1);      // no-op reports status only
    send(OP_START, 1'b0);
    send(OP_TICK, 1'b1);     // zero interval expires at once, rearm
    send(OP_TICK, 1'b1);     // attempt hits limit, go idle
    send(OP_TICK, 1'b0);
    send(OP_START, 1'b1);
    send(OP_START, 1'b0);    // restart while armed
    send(OP_STOP, 1'b1);
    send(OP_START, 1'b0);
    send(OP_TICK, 1'b0);     // expiry without retry
    send(OP_NOP, 1'b0);
    send(OP_START, 1'b1);
    drain();

    // New values must not touch the running countdown.
    program_regs(16'hFFFF, 255, 0);
    send(OP_TICK, 1'b1);
    send(OP_STOP, 1'b0);
    send(OP_START, 1'b0);
    send(OP_TICK, 1'b1);
    send(OP_TICK, 1'b0);
    send(OP_NOP, 1'b1);
    drain();

    // Random phases.
    phases.push_back('{500, 3, 1, 40, 1'b0, 1'b1, 1'b0});
    phases.push_back('{1, 3, 1, 200, 1'b0, 1'b0, 1'b0});
    phases.push_back('{2, 6, 0, 200, 1'b0, 1'b0, 1'b1});
    phases.push_back('{1, 255, 0, 270, 1'b1, 1'b0, 1'b0});
    phases.push_back('{1, 0, 15, 150, 1'b0, 1'b1, 1'b0});
    phases.push_back('{3, 4, 15, 120, 1'b0, 1'b0, 1'b0});
    phases.push_back('{0, 5, 7, 60, 1'b0, 1'b0, 1'b0});
    repeat (4) begin
      phases.push_back('{$urandom_range(1, 6), $urandom_range(0, 12),
                         $urandom_range(0, 15), 60, 1'b0, 1'b0, 1'b0});
    end

    foreach (phases[i]) begin
      ph = phases[i];
      tx_gap_max   = ph.eager ? 0 : 3;
      rx_stall_max = ph.eager ? 0 : 3;
      program_regs(ph.init_iv, ph.limit, ph.delta);
      if (ph.chain) send(OP_START, 1'b1);
      for (k = 0; k < ph.n_words; k++) begin
        // Let the sink hold off while the source keeps offering words.
        if (ph.hold && k == 20) hold_req = 1'b1;
        send_random(ph.chain);
      end
      // Pause the source until every result is back before reprogramming.
      drain();
    end

    tx_gap_max   = 3;
    rx_stall_max = 3;
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
